// File: rtl/core/sfh_pkg.sv
// ----------------------------------------------------------------------------
// sfh_pkg
// Shared types and constants for the SPI frame header sync receiver.
// ----------------------------------------------------------------------------
package sfh_pkg;

    localparam int unsigned FRAME_PIXELS = 784;
    localparam int unsigned PIX_W        = 10;
    localparam int unsigned FILL_W       = 12;

    localparam logic [7:0] CMD_CAPTURE = 8'hC0;
    localparam logic [7:0] HDR_FIRST   = 8'hAA;
    localparam logic [7:0] HDR_SECOND  = 8'h55;
    localparam logic [7:0] FILLER_BYTE = 8'h00;

    localparam logic [FILL_W-1:0] FILLER_RESET = FILL_W'(4000);

    localparam logic [PIX_W-1:0] FRAME_PIXELS_V = PIX_W'(FRAME_PIXELS);

    localparam logic [1:0] KIND_TRIGGER = 2'd0;
    localparam logic [1:0] KIND_BYTE    = 2'd1;
    localparam logic [1:0] KIND_ABORT   = 2'd2;

    localparam logic CFG_MODE_ENABLE = 1'b0;
    localparam logic CFG_MAX_FILLER  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SYNC = 3'd1,
        PH_HDR1 = 3'd2,
        PH_IMG  = 3'd3,
        PH_DONE = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_BUSY     = 3'd1,
        ST_MODE_OFF = 3'd2,
        ST_TIMEOUT  = 3'd3,
        ST_COMPLETE = 3'd4
    } t_status;

    typedef struct packed {
        logic              mode_enable;
        logic [FILL_W-1:0] max_filler_bytes;
    } t_cfg;

    typedef struct packed {
        logic             send_valid;
        logic [7:0]       send_byte;
        logic             slave_selected;
        logic             pixel_valid;
        logic [PIX_W-1:0] pixel_index;
        logic [7:0]       pixel_value;
        t_status          status;
    } t_result;

endpackage

// File: rtl/core/sfh_cfg_regs.sv
// ----------------------------------------------------------------------------
// sfh_cfg_regs
// Configuration register file: mode enable and header hunt filler limit.
// ----------------------------------------------------------------------------
module sfh_cfg_regs (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic                     i_wr_index,
    input  logic [sfh_pkg::FILL_W-1:0] i_wr_data,
    output sfh_pkg::t_cfg            o_cfg
);
    import sfh_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode_enable      <= 1'b0;
            r_cfg.max_filler_bytes <= FILLER_RESET;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_MODE_ENABLE: r_cfg.mode_enable      <= i_wr_data[0];
                CFG_MAX_FILLER:  r_cfg.max_filler_bytes <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/sfh_deframer.sv
// ----------------------------------------------------------------------------
// sfh_deframer
// Capture phase machine: header hunt, timeout, pixel indexing, chip select.
// ----------------------------------------------------------------------------
module sfh_deframer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [1:0]       i_kind,
    input  logic [7:0]       i_rx_byte,
    input  sfh_pkg::t_cfg    i_cfg,
    output sfh_pkg::t_result o_result
);
    import sfh_pkg::*;

    t_phase             r_phase, n_phase;
    logic [PIX_W-1:0]   r_pix, n_pix;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic               r_sel, n_sel;

    logic [FILL_W-1:0]  fill_inc;
    logic [PIX_W-1:0]   pix_inc;
    logic               ended;
    logic               mid_frame_now;
    t_result            res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pix   <= '0;
            r_fill  <= '0;
            r_sel   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_pix   <= n_pix;
            r_fill  <= n_fill;
            r_sel   <= n_sel;
        end
    end

    assign fill_inc      = (r_fill != '1) ? r_fill + 1'b1 : r_fill;
    assign pix_inc       = r_pix + 1'b1;
    assign mid_frame_now = (r_phase == PH_SYNC) || (r_phase == PH_HDR1)
                        || (r_phase == PH_IMG);

    always_comb begin
        n_phase    = r_phase;
        n_pix      = r_pix;
        n_fill     = r_fill;
        n_sel      = r_sel;
        ended      = 1'b0;
        res        = '0;
        res.status = ST_NONE;

        unique case (i_kind)
            KIND_TRIGGER: begin
                if (!i_cfg.mode_enable) begin
                    res.status = ST_MODE_OFF;
                end else if (mid_frame_now) begin
                    res.status = ST_BUSY;
                end else begin
                    n_phase        = PH_SYNC;
                    n_pix          = '0;
                    n_fill         = '0;
                    n_sel          = 1'b1;
                    res.send_valid = 1'b1;
                    res.send_byte  = CMD_CAPTURE;
                end
            end
            KIND_BYTE: begin
                unique case (r_phase)
                    PH_SYNC: begin
                        n_fill = fill_inc;
                        if (i_rx_byte == HDR_FIRST) begin
                            n_phase = PH_HDR1;
                        end else if (fill_inc >= i_cfg.max_filler_bytes) begin
                            n_phase    = PH_IDLE;
                            n_sel      = 1'b0;
                            res.status = ST_TIMEOUT;
                            ended      = 1'b1;
                        end
                    end
                    PH_HDR1: begin
                        if (i_rx_byte == HDR_SECOND) begin
                            n_phase = PH_IMG;
                            n_pix   = '0;
                        end else if (i_rx_byte != HDR_FIRST) begin
                            n_phase = PH_SYNC;
                        end
                    end
                    PH_IMG: begin
                        res.pixel_valid = 1'b1;
                        res.pixel_index = r_pix;
                        res.pixel_value = i_rx_byte;
                        n_pix           = pix_inc;
                        if (pix_inc == '0 || pix_inc >= FRAME_PIXELS_V) begin
                            n_phase    = PH_DONE;
                            n_sel      = 1'b0;
                            res.status = ST_COMPLETE;
                            ended      = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (!ended && (n_phase == PH_SYNC || n_phase == PH_HDR1
                               || n_phase == PH_IMG)) begin
                    res.send_valid = 1'b1;
                    res.send_byte  = FILLER_BYTE;
                end
            end
            KIND_ABORT: begin
                n_phase = PH_IDLE;
                n_sel   = 1'b0;
            end
            default: ;
        endcase

        res.slave_selected = n_sel;
    end

    assign o_result = res;

endmodule

// File: rtl/core/spi_frame_header_sync_receiver.sv
// ----------------------------------------------------------------------------
// spi_frame_header_sync_receiver
// Master-side SPI capture receiver with two-byte sync header deframing.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one item: a capture
// trigger, a byte received from the slave, or an abort. Each item yields
// exactly one result on the output channel (o_out_valid / i_out_stall):
// the next byte to clock out, the chip select level, an optional image
// byte with its pixel index, and a status code.
// An item waits in the input register, the phase machine works on it and
// the result register captures its result when the output can advance:
// one item per cycle sustained while the output does not stall. The
// rate is set by the single pass through the phase and counter update.
// While the receiver stalls, the result register holds; one more item
// can wait in the input register, after which o_in_stall rises.
// The configuration port (i_cfg_valid / o_cfg_ready) is always ready;
// index 0 is mode enable, index 1 the filler byte limit.
// Synchronous reset clears the pipeline, returns to idle with the slave
// deselected, and loads mode off and a limit of 4000 filler bytes.
// ----------------------------------------------------------------------------
module spi_frame_header_sync_receiver (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_kind,
    input  logic [7:0]                 i_rx_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_send_valid,
    output logic [7:0]                 o_send_byte,
    output logic                       o_slave_selected,
    output logic                       o_pixel_valid,
    output logic [sfh_pkg::PIX_W-1:0]  o_pixel_index,
    output logic [7:0]                 o_pixel_value,
    output logic [2:0]                 o_status,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [sfh_pkg::FILL_W-1:0] i_cfg_data
);
    import sfh_pkg::*;

    logic       r_in_valid;
    logic [1:0] r_in_kind;
    logic [7:0] r_in_rx;
    logic       r_out_valid;
    t_result    r_out;

    t_cfg    cfg;
    t_result result;
    logic    advance;
    logic    fire;
    logic    in_accept;

    assign o_cfg_ready = 1'b1;

    sfh_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_kind <= i_kind;
            r_in_rx   <= i_rx_byte;
        end
    end

    sfh_deframer u_deframer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_kind    (r_in_kind),
        .i_rx_byte (r_in_rx),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_send_valid     = r_out.send_valid;
    assign o_send_byte      = r_out.send_byte;
    assign o_slave_selected = r_out.slave_selected;
    assign o_pixel_valid    = r_out.pixel_valid;
    assign o_pixel_index    = r_out.pixel_index;
    assign o_pixel_value    = r_out.pixel_value;
    assign o_status         = r_out.status;

endmodule

// File: tb/sfh_capture_checker.sv
// ----------------------------------------------------------------------------
// sfh_capture_checker
// Predicts and checks every result of the SPI frame header sync receiver.
// ----------------------------------------------------------------------------
// Watches the item, result and register channels. Each accepted item runs
// through an untimed copy of the capture phase machine and the result it
// should produce is queued. Each accepted result is compared field by field
// with the oldest queued one. Reports the mismatch count and the number of
// results still owed.
// ----------------------------------------------------------------------------
module sfh_capture_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [1:0]                 i_kind,
    input  logic [7:0]                 i_rx_byte,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic                       i_send_valid,
    input  logic [7:0]                 i_send_byte,
    input  logic                       i_slave_selected,
    input  logic                       i_pixel_valid,
    input  logic [sfh_pkg::PIX_W-1:0]  i_pixel_index,
    input  logic [7:0]                 i_pixel_value,
    input  logic [2:0]                 i_status,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [sfh_pkg::FILL_W-1:0] i_cfg_data,
    output int                         o_results_owed,
    output int                         o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import sfh_pkg::*;

    t_cfg              regs;
    t_phase            phase;
    logic [PIX_W-1:0]  pixels_taken;
    logic [FILL_W-1:0] fillers_seen;
    logic              selected;
    t_result           owed_results[$];
    t_result           want;
    int                owed_count = 0;
    int                mismatches = 0;

    assign o_results_owed = owed_count;
    assign o_mismatches   = mismatches;

    function automatic t_result capture_step(input logic [1:0] kind, input logic [7:0] rx);
        t_result r;
        logic    ended;
        r     = '0;
        ended = 1'b0;
        case (kind)
            KIND_TRIGGER: begin
                if (!regs.mode_enable) begin
                    r.status = ST_MODE_OFF;
                end else if (phase inside {PH_SYNC, PH_HDR1, PH_IMG}) begin
                    r.status = ST_BUSY;
                end else begin
                    phase        = PH_SYNC;
                    pixels_taken = '0;
                    fillers_seen = '0;
                    selected     = 1'b1;
                    r.send_valid = 1'b1;
                    r.send_byte  = CMD_CAPTURE;
                end
            end
            KIND_BYTE: begin
                case (phase)
                    PH_SYNC: begin
                        if (fillers_seen != '1) fillers_seen = fillers_seen + 1'b1;
                        if (rx == HDR_FIRST) begin
                            phase = PH_HDR1;
                        end else if (fillers_seen >= regs.max_filler_bytes) begin
                            phase    = PH_IDLE;
                            selected = 1'b0;
                            r.status = ST_TIMEOUT;
                            ended    = 1'b1;
                        end
                    end
                    PH_HDR1: begin
                        if (rx == HDR_SECOND) begin
                            phase        = PH_IMG;
                            pixels_taken = '0;
                        end else if (rx != HDR_FIRST) begin
                            phase = PH_SYNC;
                        end
                    end
                    PH_IMG: begin
                        r.pixel_valid = 1'b1;
                        r.pixel_index = pixels_taken;
                        r.pixel_value = rx;
                        pixels_taken  = pixels_taken + 1'b1;
                        if (pixels_taken == '0 || pixels_taken >= FRAME_PIXELS_V) begin
                            phase    = PH_DONE;
                            selected = 1'b0;
                            r.status = ST_COMPLETE;
                            ended    = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (!ended && phase inside {PH_SYNC, PH_HDR1, PH_IMG}) begin
                    r.send_valid = 1'b1;
                    r.send_byte  = FILLER_BYTE;
                end
            end
            KIND_ABORT: begin
                phase    = PH_IDLE;
                selected = 1'b0;
            end
            default: ;
        endcase
        r.slave_selected = selected;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.mode_enable      = 1'b0;
            regs.max_filler_bytes = FILLER_RESET;
            phase                 = PH_IDLE;
            pixels_taken          = '0;
            fillers_seen          = '0;
            selected              = 1'b0;
            owed_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_MODE_ENABLE) regs.mode_enable = i_cfg_data[0];
                else regs.max_filler_bytes = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    $error("result with no item outstanding");
                    mismatches++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("send_valid", 32'(want.send_valid), 32'(i_send_valid));
                    check_field("send_byte", 32'(want.send_byte), 32'(i_send_byte));
                    check_field("slave_selected", 32'(want.slave_selected),
                                32'(i_slave_selected));
                    check_field("pixel_valid", 32'(want.pixel_valid), 32'(i_pixel_valid));
                    check_field("pixel_index", 32'(want.pixel_index), 32'(i_pixel_index));
                    check_field("pixel_value", 32'(want.pixel_value), 32'(i_pixel_value));
                    check_field("status", 32'(want.status), 32'(i_status));
                end
            end
            if (i_in_valid && !i_in_stall) owed_results.push_back(capture_step(i_kind, i_rx_byte));
        end
        owed_count = owed_results.size();
    end

endmodule

// File: tb/spi_frame_header_sync_receiver_test.sv
// ----------------------------------------------------------------------------
// spi_frame_header_sync_receiver_test
// Stimulus and verdict for the SPI frame header sync receiver.
// ----------------------------------------------------------------------------
// Drives a directed pass over refused triggers, header resync, timeouts,
// a full frame and aborts, then random capture attempts under changing
// register settings with random idle bursts on both channels and one long
// result hold-off. Checking is done by the capture checker instantiated
// beside the block.
// ----------------------------------------------------------------------------
module spi_frame_header_sync_receiver_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sfh_pkg::*;

    localparam logic [1:0] KIND_SPARE    = 2'd3;
    localparam int         RANDOM_ITEMS  = 550;
    localparam int         CALM_ITEMS    = 200;
    localparam int         PRESSURE_HOLD = 300;
    localparam int         QUIET_LIMIT   = 4000;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [1:0]        kind         = KIND_TRIGGER;
    logic [7:0]        rx_byte      = 8'h00;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic              send_valid;
    logic [7:0]        send_byte;
    logic              slave_selected;
    logic              pixel_valid;
    logic [PIX_W-1:0]  pixel_index;
    logic [7:0]        pixel_value;
    logic [2:0]        status;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic              cfg_index    = CFG_MODE_ENABLE;
    logic [FILL_W-1:0] cfg_data     = '0;

    int   results_owed;
    int   mismatches;
    int   items_sent     = 0;
    int   calm_from      = 32'h7fff_ffff;
    int   quiet_cycles   = 0;
    logic gaps_on        = 1'b1;
    logic stalls_on      = 1'b1;
    logic tail_calm      = 1'b0;
    logic pressure_phase = 1'b0;
    logic pressure_done  = 1'b0;

    always #5 clk = ~clk;

    spi_frame_header_sync_receiver u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_kind           (kind),
        .i_rx_byte        (rx_byte),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_send_valid     (send_valid),
        .o_send_byte      (send_byte),
        .o_slave_selected (slave_selected),
        .o_pixel_valid    (pixel_valid),
        .o_pixel_index    (pixel_index),
        .o_pixel_value    (pixel_value),
        .o_status         (status),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    sfh_capture_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_kind           (kind),
        .i_rx_byte        (rx_byte),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_send_valid     (send_valid),
        .i_send_byte      (send_byte),
        .i_slave_selected (slave_selected),
        .i_pixel_valid    (pixel_valid),
        .i_pixel_index    (pixel_index),
        .i_pixel_value    (pixel_value),
        .i_status         (status),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_results_owed   (results_owed),
        .o_mismatches     (mismatches)
    );

    task automatic offer(input logic [1:0] k, input logic [7:0] b);
        if (gaps_on && !tail_calm && !pressure_phase && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (items_sent >= calm_from) tail_calm = 1'b1;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        repeat (3) @(posedge clk);
        wait (results_owed == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [FILL_W-1:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic offer_pixels(input int count);
        repeat (count) offer(KIND_BYTE, 8'($urandom_range(0, 255)));
    endtask

    task automatic capture_attempt();
        int noise;
        gaps_on = $urandom_range(0, 3) != 0;
        offer(KIND_TRIGGER, 8'($urandom_range(0, 255)));
        noise = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 4);
        repeat (noise) offer(KIND_BYTE, 8'($urandom_range(0, 255)));
        case ($urandom_range(0, 5))
            0: begin
                offer(KIND_BYTE, HDR_FIRST);
                offer(KIND_BYTE, 8'($urandom_range(0, 255)));
                offer(KIND_BYTE, HDR_FIRST);
            end
            1: begin
                offer(KIND_BYTE, HDR_FIRST);
                offer(KIND_BYTE, HDR_FIRST);
            end
            default: offer(KIND_BYTE, HDR_FIRST);
        endcase
        offer(KIND_BYTE, HDR_SECOND);
        case ($urandom_range(0, 3))
            0: offer_pixels(FRAME_PIXELS + $urandom_range(0, 2));
            1: begin
                offer_pixels($urandom_range(0, 60));
                offer(KIND_ABORT, 8'($urandom_range(0, 255)));
            end
            2: begin
                offer_pixels($urandom_range(0, 30));
                offer(KIND_TRIGGER, 8'($urandom_range(0, 255)));
                offer_pixels($urandom_range(0, 30));
            end
            default: offer_pixels($urandom_range(0, 80));
        endcase
        if ($urandom_range(0, 3) == 0)
            offer(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    // receiver side: random stall bursts, one long hold-off on request
    initial begin : receiver
        int run_left;
        int held;
        run_left = 0;
        @(posedge clk);
        forever begin
            if (pressure_phase && !pressure_done) begin
                out_stall <= 1'b1;
                for (held = 0; held < PRESSURE_HOLD; held++) @(posedge clk);
                pressure_done = 1'b1;
            end else if (stalls_on && !tail_calm && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end else begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            if (run_left == 0) begin
                stalls_on = $urandom_range(0, 3) != 0;
                run_left  = $urandom_range(50, 400);
            end else begin
                run_left--;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("spi_frame_header_sync_receiver_test: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [FILL_W-1:0] limit_val;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: mode off
        offer(KIND_TRIGGER, 8'h00);
        offer(KIND_BYTE, 8'hFF);
        offer(KIND_ABORT, 8'h00);
        offer(KIND_SPARE, 8'hFF);

        write_reg(CFG_MODE_ENABLE, 12'hFFF);
        write_reg(CFG_MAX_FILLER, 12'd3);
        offer(KIND_TRIGGER, 8'h00);
        offer(KIND_TRIGGER, 8'hFF);
        offer(KIND_BYTE, 8'h00);
        offer(KIND_BYTE, 8'h7F);
        offer(KIND_BYTE, 8'hFF);

        // header resync and abort mid image
        offer(KIND_TRIGGER, 8'h00);
        offer(KIND_BYTE, HDR_FIRST);
        offer(KIND_BYTE, HDR_FIRST);
        offer(KIND_BYTE, 8'h12);
        offer(KIND_BYTE, HDR_FIRST);
        offer(KIND_BYTE, HDR_SECOND);
        offer(KIND_BYTE, 8'h00);
        offer(KIND_BYTE, 8'hFF);
        offer(KIND_TRIGGER, 8'h00);
        offer(KIND_ABORT, 8'h00);

        // full frame, then byte and trigger in done
        offer(KIND_TRIGGER, 8'h00);
        offer(KIND_BYTE, HDR_FIRST);
        offer(KIND_BYTE, HDR_SECOND);
        offer_pixels(FRAME_PIXELS);
        offer(KIND_BYTE, 8'h44);
        offer(KIND_TRIGGER, 8'h00);

        // mode cleared mid capture
        write_reg(CFG_MODE_ENABLE, 12'hFFE);
        offer(KIND_BYTE, 8'h33);
        offer(KIND_TRIGGER, 8'h00);
        offer(KIND_ABORT, 8'h00);

        write_reg(CFG_MODE_ENABLE, 12'h001);
        write_reg(CFG_MAX_FILLER, 12'd1);
        offer(KIND_TRIGGER, 8'h00);
        offer(KIND_BYTE, 8'h5A);

        write_reg(CFG_MAX_FILLER, 12'd0);
        offer(KIND_TRIGGER, 8'h00);
        offer(KIND_BYTE, HDR_FIRST);
        offer(KIND_BYTE, 8'h00);
        offer(KIND_BYTE, 8'h01);

        // receiver holds off while items keep coming
        write_reg(CFG_MAX_FILLER, 12'd4000);
        gaps_on        = 1'b1;
        pressure_phase = 1'b1;
        offer(KIND_TRIGGER, 8'h00);
        offer(KIND_BYTE, HDR_FIRST);
        offer(KIND_BYTE, HDR_SECOND);
        offer_pixels(40);
        wait (pressure_done);
        pressure_phase = 1'b0;

        calm_from = items_sent + RANDOM_ITEMS - CALM_ITEMS;
        while (items_sent < calm_from + CALM_ITEMS) begin
            if (!tail_calm) begin
                write_reg(CFG_MODE_ENABLE,
                          {11'($urandom_range(0, 2047)), 1'($urandom_range(0, 7) != 0)});
                case ($urandom_range(0, 5))
                    0: limit_val = 12'd1;
                    1: limit_val = 12'd4095;
                    2: limit_val = 12'($urandom_range(0, 4095));
                    default: limit_val = 12'($urandom_range(2, 40));
                endcase
                write_reg(CFG_MAX_FILLER, limit_val);
            end
            repeat ($urandom_range(1, 3)) capture_attempt();
        end

        settle();
        if (mismatches == 0)
            $display("spi_frame_header_sync_receiver_test: clean");
        else
            $display("spi_frame_header_sync_receiver_test: errors");
        $finish;
    end

endmodule

// File: spi_frame_header_sync_receiver.f
rtl/core/sfh_pkg.sv
rtl/core/sfh_cfg_regs.sv
rtl/core/sfh_deframer.sv
rtl/core/spi_frame_header_sync_receiver.sv
tb/sfh_capture_checker.sv
tb/spi_frame_header_sync_receiver_test.sv
